// File: rtl/core/ps2_scan_set1_key_decoder_unit_defines.svh
// Assertion helpers used by the decoder unit.
`ifndef PS2_SCAN_SET1_KEY_DECODER_UNIT_DEFINES_SVH
`define PS2_SCAN_SET1_KEY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PS2S1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2s1 same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PS2S1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2s1 next-cycle check failed");

`endif

// File: rtl/core/ps2s1_pkg.sv
package ps2s1_pkg;

  // Key groups as seen on the result channel
  localparam logic [1:0] GRP_PLAIN = 2'd0;
  localparam logic [1:0] GRP_EXT   = 2'd1;
  localparam logic [1:0] GRP_PRINT = 2'd2;
  localparam logic [1:0] GRP_PAUSE = 2'd3;

  localparam logic [7:0] EXT_PREFIX = 8'hE0;
  localparam logic [6:0] CODE_MASK  = 7'h7F;

  // Special sequences
  localparam logic [2:0] PRINT_LEN = 3'd4;
  localparam logic [2:0] PAUSE_LEN = 3'd6;
  localparam logic [7:0] PMAKE_SEQ  [4] = '{8'hE0, 8'h2A, 8'hE0, 8'h37};
  localparam logic [7:0] PBREAK_SEQ [4] = '{8'hE0, 8'hB7, 8'hE0, 8'hAA};
  localparam logic [7:0] PAUSE_SEQ  [6] = '{8'hE1, 8'h1D, 8'h45, 8'hE1, 8'h9D, 8'hC5};

  // Plain code range limits
  localparam logic [6:0] PLAIN_LO  = 7'h01;
  localparam logic [6:0] PLAIN_HI  = 7'h53;
  localparam logic [6:0] PLAIN_F11 = 7'h57;
  localparam logic [6:0] PLAIN_F12 = 7'h58;

  // Sequence tracking state
  typedef struct packed {
    logic       ext;
    logic [2:0] pmake;
    logic [2:0] pbreak;
    logic [2:0] pause;
  } dec_state_t;

  // One decoded result
  typedef struct packed {
    logic       hit;
    logic [1:0] group;
    logic [6:0] code;
    logic       rel;
  } dec_res_t;

  function automatic logic plain_known(input logic [6:0] c);
    plain_known = (c >= PLAIN_LO && c <= PLAIN_HI) || c == PLAIN_F11 || c == PLAIN_F12;
  endfunction

  function automatic logic ext_known(input logic [6:0] c);
    case (c) inside
      7'h1C, 7'h1D, 7'h35, 7'h38,
      [7'h47:7'h49], 7'h4B, 7'h4D,
      [7'h4F:7'h53], [7'h5B:7'h5D]: ext_known = 1'b1;
      default:                      ext_known = 1'b0;
    endcase
  endfunction

endpackage

// File: rtl/core/ps2s1_ifs.sv
// Scan byte channel
interface ps2s1_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

// Decoded key channel
interface ps2s1_key_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_group;
  logic [6:0] key_code;
  logic       is_release;

  modport source (output valid, output key_group, output key_code, output is_release,
                  input ready);
  modport sink   (input valid, input key_group, input key_code, input is_release,
                  output ready);
endinterface

// File: rtl/core/ps2_scan_set1_key_decoder_unit.sv
// Set-1 scan byte to key decoder.
// Path: input register, a single decode pass, then the result register.
// Throughput: one byte per cycle unless a byte with a result finds the output full.
// Bytes that decode to nothing leave no result and never wait on the result side.
// Reset: synchronous, active low; clears both valid flags, the E0 flag and all sequence counters.
`include "ps2_scan_set1_key_decoder_unit_defines.svh"

module ps2_scan_set1_key_decoder_unit (
  input logic           clk,
  input logic           rst_n,
  ps2s1_byte_if.sink    in_if,
  ps2s1_key_if.source   out_if
);
  import ps2s1_pkg::*;

  logic       in_vld_r;
  logic [7:0] byte_r;
  dec_state_t st_r, st_nxt;
  dec_res_t   res;
  logic       out_vld_r, out_vld_nxt;
  logic [1:0] group_r;
  logic [6:0] code_r;
  logic       rel_r;
  logic       advance, emit;

  ps2s1_decode u_decode (
    .scan_byte (byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // Handshake: the held byte moves on unless its result finds the output full
  assign advance     = in_vld_r && (!res.hit || !out_vld_r || out_if.ready);
  assign emit        = advance && res.hit;
  assign in_if.ready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      byte_r <= in_if.scan_byte;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      group_r <= res.group;
      code_r  <= res.code;
      rel_r   <= res.rel;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.key_group  = group_r;
  assign out_if.key_code   = code_r;
  assign out_if.is_release = rel_r;

  // Checks
  `PS2S1_ASSERT_IMPL(a_seq_code_zero, clk, rst_n, out_vld_r && group_r[1], code_r == 7'd0)
  `PS2S1_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit, {st_r.pmake, st_r.pbreak, st_r.pause} == 9'd0)
  `PS2S1_ASSERT_NEXT(a_prefix_flag, clk, rst_n, advance, st_r.ext == ($past(byte_r) == EXT_PREFIX))
  `PS2S1_ASSERT_IMPL(a_print_range, clk, rst_n, 1'b1, st_r.pmake < PRINT_LEN && st_r.pbreak < PRINT_LEN)

endmodule

// File: rtl/core/ps2s1_decode.sv
module ps2s1_decode (
  input  logic [7:0]             scan_byte,
  input  ps2s1_pkg::dec_state_t  st,
  output ps2s1_pkg::dec_state_t  st_nxt,
  output ps2s1_pkg::dec_res_t    res
);
  import ps2s1_pkg::*;

  logic       pm_ok, pb_ok, pa_ok;
  logic [2:0] pm_n, pb_n, pa_n;
  logic       pm_done, pb_done, pa_done;
  logic [6:0] low;

  assign low = scan_byte[6:0] & CODE_MASK;

  // Sequence counters: advance on match, else drop to zero
  always_comb begin
    pm_ok = (st.pmake  < PRINT_LEN) && (PMAKE_SEQ[st.pmake[1:0]]   == scan_byte);
    pb_ok = (st.pbreak < PRINT_LEN) && (PBREAK_SEQ[st.pbreak[1:0]] == scan_byte);
    pa_ok = (st.pause  < PAUSE_LEN) && (PAUSE_SEQ[st.pause]        == scan_byte);
    pm_n  = pm_ok ? st.pmake  + 3'd1 : 3'd0;
    pb_n  = pb_ok ? st.pbreak + 3'd1 : 3'd0;
    pa_n  = pa_ok ? st.pause  + 3'd1 : 3'd0;
    pm_done = pm_ok && pm_n == PRINT_LEN;
    pb_done = pb_ok && pb_n == PRINT_LEN;
    pa_done = pa_ok && pa_n == PAUSE_LEN;
  end

  // Result select: Pause first, then Print break, then Print make, then table lookup
  always_comb begin
    res = '0;
    if (pa_done) begin
      res.hit   = 1'b1;
      res.group = GRP_PAUSE;
    end else if (pb_done) begin
      res.hit   = 1'b1;
      res.group = GRP_PRINT;
      res.rel   = 1'b1;
    end else if (pm_done) begin
      res.hit   = 1'b1;
      res.group = GRP_PRINT;
    end else begin
      res.code = low;
      res.rel  = scan_byte[7];
      if (st.ext) begin
        res.hit   = ext_known(low);
        res.group = GRP_EXT;
      end else begin
        res.hit   = plain_known(low);
        res.group = GRP_PLAIN;
      end
    end
  end

  // Next state: any result clears the counters
  always_comb begin
    st_nxt.ext    = (scan_byte == EXT_PREFIX);
    st_nxt.pmake  = res.hit ? 3'd0 : pm_n;
    st_nxt.pbreak = res.hit ? 3'd0 : pb_n;
    st_nxt.pause  = res.hit ? 3'd0 : pa_n;
  end

endmodule
